// ===== src/frlsh_pkg.sv =====
// ----------------------------------------------------------------------------
// frlsh_pkg
// Shared types, codes and constants of the frequency relay load shedder.
// ----------------------------------------------------------------------------
`default_nettype none

package frlsh_pkg;

	localparam int LOAD_COUNT_DEF = 5;
	localparam int LOAD_COUNT_MAX = 16;
	localparam int OUT_LOADS      = 5;

	localparam int FREQ_W  = 24;
	localparam int COUNT_W = 16;
	localparam int ROC_W   = 32;
	localparam int RTHR_W  = 31;
	localparam int TICK_W  = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int NUM_W  = 73;
	localparam int DEN_W  = 35;
	localparam int REM_W  = DEN_W + 1;
	localparam int SUM_W  = FREQ_W + 1;
	localparam int FP_W   = 2 * FREQ_W;
	localparam int PART_W = SUM_W + FREQ_W;
	localparam int CNT_W  = 7;

	localparam logic [FREQ_W-1:0] FREQ_NUMER  = 24'd16000000;
	localparam logic [9:0]        MHZ_SCALE   = 10'd1000;
	localparam logic [CNT_W-1:0]  FDIV_STEPS  = 7'd24;
	localparam logic [CNT_W-1:0]  RDIV_STEPS  = 7'd73;

	localparam logic [FREQ_W-1:0] FREQ_THR_RST = 24'd49000;
	localparam logic [RTHR_W-1:0] ROC_THR_RST  = 31'd10000;
	localparam logic [TICK_W-1:0] PERIOD_RST   = 16'd500;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_SWITCH = 2'd2,
		OP_BUTTON = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_ON      = 2'd1,
		MODE_MANAGED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_FREQ_THR = 2'd0,
		REG_ROC_THR  = 2'd1,
		REG_PERIOD   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic mul1;
		logic mul2;
		logic mul3;
		logic mul4;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== src/frlsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// frlsh_ctrl
// Sequencer: division and products for a sample, then the update for any item.
// ----------------------------------------------------------------------------
`default_nettype none

module frlsh_ctrl
	import frlsh_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire op_t     operation,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FDIV  = 8'b0000_0010,
		S_MUL1  = 8'b0000_0100,
		S_MUL2  = 8'b0000_1000,
		S_MUL3  = 8'b0001_0000,
		S_MUL4  = 8'b0010_0000,
		S_RDIV  = 8'b0100_0000,
		S_APPLY = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_n = (operation == OP_SAMPLE) ? S_FDIV : S_APPLY;
				end
			end
			S_FDIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_n  = S_MUL4;
			end
			S_MUL4: begin
				cmd.mul4 = 1'b1;
				state_n  = S_RDIV;
			end
			S_RDIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = S_APPLY;
				end
			end
			S_APPLY: begin
				if (status.out_free) begin
					cmd.apply = 1'b1;
					state_n   = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/frlsh_dp.sv =====
// ----------------------------------------------------------------------------
// frlsh_dp
// Datapath: serial divider, product registers, relay state and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module frlsh_dp
	import frlsh_pkg::*;
#(
	parameter int LOAD_COUNT = LOAD_COUNT_DEF
)(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	input  wire op_t                  operation,
	input  wire logic [COUNT_W-1:0]   period_count,
	input  wire logic [OUT_LOADS-1:0] switch_bits,
	input  wire logic [FREQ_W-1:0]    freq_thr,
	input  wire logic [RTHR_W-1:0]    roc_thr,
	input  wire logic [TICK_W-1:0]    period,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [OUT_LOADS-1:0]      load_on_bits,
	output logic [OUT_LOADS-1:0]      load_shed_bits,
	output logic                      grid_stable,
	output logic                      shedding_active,
	output logic                      maintenance_mode,
	output logic [FREQ_W-1:0]         frequency_mhz,
	output logic signed [ROC_W-1:0]   roc_mhz_s
);

	op_t                  op_q;
	logic [OUT_LOADS-1:0] sw_q;
	logic                 czero_q;

	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [ROC_W-1:0]  quo_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [FREQ_W-1:0] f_q;
	logic [FP_W-1:0]   fp_q;
	logic [SUM_W-1:0]  a_q;
	logic              neg_q;
	logic              zsum_q;
	logic [PART_W-1:0] plo_q;
	logic [PART_W-1:0] phi_q;

	logic [FREQ_W-1:0]      prev_q;
	logic signed [ROC_W-1:0] roc_q;
	mode_t                  mode_q [LOAD_COUNT];
	logic                   stable_q;
	logic                   shed_q;
	logic                   maint_q;
	logic                   run_q;
	logic [TICK_W-1:0]      tcnt_q;

	logic [REM_W-1:0]  r2;
	logic              ge;
	logic [FREQ_W-1:0] f_div;
	logic [SUM_W-1:0]  sum;
	logic [FREQ_W-1:0] diff;

	assign status.div_last = (cnt_q == CNT_W'(1));
	assign status.out_free = !result_valid || result_ready;

	assign r2    = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge    = (r2 >= {1'b0, den_q});
	assign f_div = czero_q ? '0 : quo_q[FREQ_W-1:0];
	assign sum   = {1'b0, f_div} + {1'b0, prev_q};
	assign diff  = (f_div < prev_q) ? (prev_q - f_div) : (f_div - prev_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			sw_q    <= switch_bits;
			czero_q <= (period_count == '0);
			num_q   <= {FREQ_NUMER, {(NUM_W-FREQ_W){1'b0}}};
			den_q   <= DEN_W'(period_count);
			rem_q   <= '0;
			quo_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? (r2 - {1'b0, den_q}) : r2;
			quo_q <= {quo_q[ROC_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[ROC_W-1];
		end else if (cmd.mul1) begin
			f_q    <= f_div;
			fp_q   <= f_div * prev_q;
			a_q    <= {diff, 1'b0};
			neg_q  <= (f_div < prev_q);
			zsum_q <= (sum == '0);
			den_q  <= DEN_W'(sum) * DEN_W'(MHZ_SCALE);
		end else if (cmd.mul2) begin
			plo_q <= a_q * fp_q[FREQ_W-1:0];
		end else if (cmd.mul3) begin
			phi_q <= a_q * fp_q[FP_W-1:FREQ_W];
		end else if (cmd.mul4) begin
			num_q <= NUM_W'(plo_q) + (NUM_W'(phi_q) << FREQ_W);
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.capture) begin
			cnt_q <= FDIV_STEPS;
		end else if (cmd.mul4) begin
			cnt_q <= RDIV_STEPS;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	mode_t                   m [LOAD_COUNT];
	logic                    stable_n, shed_n, maint_n, run_n;
	logic [TICK_W-1:0]       tcnt_n;
	logic [FREQ_W-1:0]       prev_n;
	logic signed [ROC_W-1:0] roc_n;
	logic [OUT_LOADS-1:0]    on_n, sh_n;

	always_comb begin
		logic              found;
		logic              any_on;
		logic              any_man;
		logic              unstable;
		logic              want;
		logic [ROC_W-1:0]  mag;
		logic [ROC_W-1:0]  absroc;
		logic [TICK_W-1:0] t1;

		stable_n = stable_q;
		shed_n   = shed_q;
		maint_n  = maint_q;
		run_n    = run_q;
		tcnt_n   = tcnt_q;
		prev_n   = prev_q;
		roc_n    = roc_q;
		found    = 1'b0;
		any_on   = 1'b0;
		any_man  = 1'b0;
		unstable = 1'b0;
		want     = 1'b0;
		mag      = '0;
		absroc   = '0;
		t1       = '0;
		on_n     = '0;
		sh_n     = '0;
		for (int i = 0; i < LOAD_COUNT; i++) begin
			m[i] = mode_q[i];
		end

		case (op_q)
			OP_SAMPLE: begin
				mag = (ovf_q || quo_q > 32'h8000_0000) ? 32'h8000_0000 : quo_q;
				if (zsum_q) begin
					roc_n = '0;
				end else if (neg_q) begin
					roc_n = -$signed(mag);
				end else if (mag > 32'h7FFF_FFFF) begin
					roc_n = 32'sh7FFF_FFFF;
				end else begin
					roc_n = $signed(mag);
				end
				absroc = roc_n[ROC_W-1] ? (~roc_n + 32'd1) : roc_n;
				prev_n = f_q;
				if (!maint_q) begin
					unstable = (f_q < freq_thr) || (absroc >= {1'b0, roc_thr});
					if (unstable) begin
						if (stable_q) begin
							stable_n = 1'b0;
							run_n    = 1'b1;
							tcnt_n   = '0;
						end
						for (int i = 0; i < LOAD_COUNT; i++) begin
							any_on = any_on | (m[i] == MODE_ON);
						end
						if (!shed_q && any_on) begin
							shed_n = 1'b1;
							for (int i = 0; i < LOAD_COUNT; i++) begin
								if (!found && m[i] == MODE_ON) begin
									m[i]  = MODE_MANAGED;
									found = 1'b1;
								end
							end
						end
					end else if (!stable_q) begin
						stable_n = 1'b1;
						run_n    = 1'b1;
						tcnt_n   = '0;
					end
				end
			end
			OP_TICK: begin
				if (run_q) begin
					t1 = tcnt_q + TICK_W'(1);
					if (t1 < period) begin
						tcnt_n = t1;
					end else begin
						tcnt_n = '0;
						if (!maint_q) begin
							if (!stable_q) begin
								for (int i = 0; i < LOAD_COUNT; i++) begin
									if (!found && m[i] == MODE_ON) begin
										m[i]  = MODE_MANAGED;
										found = 1'b1;
									end
								end
							end else begin
								for (int i = LOAD_COUNT - 1; i >= 0; i--) begin
									if (!found && m[i] == MODE_MANAGED) begin
										m[i]  = MODE_ON;
										found = 1'b1;
									end
								end
								if (!found) begin
									shed_n = 1'b0;
									run_n  = 1'b0;
								end
							end
						end
					end
				end
			end
			OP_SWITCH: begin
				for (int i = 0; i < LOAD_COUNT; i++) begin
					want = (i < OUT_LOADS) ? sw_q[i % OUT_LOADS] : 1'b0;
					if (shed_q && !maint_q) begin
						if (!want) begin
							m[i] = MODE_OFF;
						end
					end else begin
						m[i] = want ? MODE_ON : MODE_OFF;
					end
				end
			end
			OP_BUTTON: begin
				maint_n = !maint_q;
				if (!maint_q) begin
					shed_n = 1'b0;
					run_n  = 1'b0;
					for (int i = 0; i < LOAD_COUNT; i++) begin
						if (m[i] == MODE_MANAGED) begin
							m[i] = MODE_ON;
						end
					end
				end
			end
			default: begin
				maint_n = maint_q;
			end
		endcase

		for (int i = 0; i < LOAD_COUNT; i++) begin
			any_man = any_man | (m[i] == MODE_MANAGED);
		end
		if (!any_man) begin
			shed_n = 1'b0;
			run_n  = 1'b0;
		end
		for (int i = 0; i < OUT_LOADS; i++) begin
			if (i < LOAD_COUNT) begin
				on_n[i] = (m[i % LOAD_COUNT] == MODE_ON);
				sh_n[i] = (m[i % LOAD_COUNT] == MODE_MANAGED);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			roc_q    <= '0;
			stable_q <= 1'b1;
			shed_q   <= 1'b0;
			maint_q  <= 1'b0;
			run_q    <= 1'b0;
			tcnt_q   <= '0;
			for (int i = 0; i < LOAD_COUNT; i++) begin
				mode_q[i] <= MODE_OFF;
			end
		end else if (cmd.apply) begin
			prev_q   <= prev_n;
			roc_q    <= roc_n;
			stable_q <= stable_n;
			shed_q   <= shed_n;
			maint_q  <= maint_n;
			run_q    <= run_n;
			tcnt_q   <= tcnt_n;
			for (int i = 0; i < LOAD_COUNT; i++) begin
				mode_q[i] <= m[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.apply) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			load_on_bits     <= on_n;
			load_shed_bits   <= sh_n;
			grid_stable      <= stable_n;
			shedding_active  <= shed_n;
			maintenance_mode <= maint_n;
			frequency_mhz    <= prev_n;
			roc_mhz_s        <= roc_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/frequency_relay_load_shedder_top.sv =====
// ----------------------------------------------------------------------------
// frequency_relay_load_shedder_top
// Mains frequency relay with load shedding, register port and sequencer.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Payload
// item      item_valid / item_ready     operation, period_count, switch_bits
// result    result_valid / result_ready load/flag bits, frequency_mhz, roc_mhz_s
// config    APB write/read, pready=1    freq, rate and period thresholds
//
// A frequency sample runs through the accepting state, 24 divider steps for the
// frequency, four product steps, 73 divider steps for the rate and the update,
// all on one serial divider; the next item is accepted only after the update.
// Ticks, switch polls and button presses skip the divider and go to the update.
// Reset restores thresholds, sets the stable flag and clears other relay state.
// A stalled result word holds in the output register; a new item is accepted
// meanwhile and its update waits until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_relay_load_shedder_top
	import frlsh_pkg::*;
#(
	parameter int LOAD_COUNT = LOAD_COUNT_DEF
)(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire logic [1:0]           operation,
	input  wire logic [COUNT_W-1:0]   period_count,
	input  wire logic [OUT_LOADS-1:0] switch_bits,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [OUT_LOADS-1:0]      load_on_bits,
	output logic [OUT_LOADS-1:0]      load_shed_bits,
	output logic                      grid_stable,
	output logic                      shedding_active,
	output logic                      maintenance_mode,
	output logic [FREQ_W-1:0]         frequency_mhz,
	output logic signed [ROC_W-1:0]   roc_mhz_s
);

	logic [FREQ_W-1:0] freq_thr_q;
	logic [RTHR_W-1:0] roc_thr_q;
	logic [TICK_W-1:0] period_q;
	reg_idx_t          idx;
	cmd_t              cmd;
	status_t           status;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_thr_q <= FREQ_THR_RST;
			roc_thr_q  <= ROC_THR_RST;
			period_q   <= PERIOD_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_FREQ_THR: freq_thr_q <= pwdata[FREQ_W-1:0];
				REG_ROC_THR:  roc_thr_q  <= pwdata[RTHR_W-1:0];
				REG_PERIOD:   period_q   <= pwdata[TICK_W-1:0];
				default:      period_q   <= period_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FREQ_THR: prdata = DATA_W'(freq_thr_q);
			REG_ROC_THR:  prdata = DATA_W'(roc_thr_q);
			REG_PERIOD:   prdata = DATA_W'(period_q);
			default:      prdata = '0;
		endcase
	end

	frlsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.operation  (op_t'(operation)),
		.status     (status),
		.cmd        (cmd)
	);

	frlsh_dp #(
		.LOAD_COUNT (LOAD_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.operation        (op_t'(operation)),
		.period_count     (period_count),
		.switch_bits      (switch_bits),
		.freq_thr         (freq_thr_q),
		.roc_thr          (roc_thr_q),
		.period           (period_q),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.load_on_bits     (load_on_bits),
		.load_shed_bits   (load_shed_bits),
		.grid_stable      (grid_stable),
		.shedding_active  (shedding_active),
		.maintenance_mode (maintenance_mode),
		.frequency_mhz    (frequency_mhz),
		.roc_mhz_s        (roc_mhz_s)
	);

endmodule

`default_nettype wire

// ===== src/frlsh_checker.sv =====
// ----------------------------------------------------------------------------
// frlsh_checker
// Port-level checks of the load shedder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frlsh_checker
	import frlsh_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 item_valid,
	input wire logic                 item_ready,
	input wire logic                 result_valid,
	input wire logic                 result_ready,
	input wire logic [OUT_LOADS-1:0] load_on_bits,
	input wire logic [OUT_LOADS-1:0] load_shed_bits,
	input wire logic                 shedding_active,
	input wire logic                 maintenance_mode
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(load_on_bits))
		else $error("result word dropped or changed while stalled");

	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (load_on_bits & load_shed_bits) == '0)
		else $error("a load is both on and shed");

	a_maint: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && maintenance_mode |-> !shedding_active && load_shed_bits == '0)
		else $error("shedding seen in maintenance");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("word accepted while busy");

endmodule

bind frequency_relay_load_shedder_top frlsh_checker u_frlsh_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item_valid),
	.item_ready       (item_ready),
	.result_valid     (result_valid),
	.result_ready     (result_ready),
	.load_on_bits     (load_on_bits),
	.load_shed_bits   (load_shed_bits),
	.shedding_active  (shedding_active),
	.maintenance_mode (maintenance_mode)
);

`default_nettype wire

// ===== bench/frequency_relay_load_shedder_top_tb.sv =====
// ----------------------------------------------------------------------------
// frequency_relay_load_shedder_top_tb
// Self-checking bench for the frequency relay: an in-bench predictor of the
// relay state checks every result word field by field. Stimulus is a directed
// opening followed by random phases under several threshold settings, with
// random idling and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module frequency_relay_load_shedder_top_tb;
	import frlsh_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 160;

	typedef struct {
		op_t         op;
		logic [15:0] count;
		logic [4:0]  sw;
	} relay_word_t;

	typedef struct {
		logic [4:0]         on_bits;
		logic [4:0]         shed_bits;
		logic               stable;
		logic               shedding;
		logic               maint;
		logic [23:0]        freq;
		logic signed [31:0] roc;
	} relay_status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid = 1'b0;
	logic                item_ready;
	logic [1:0]          operation = '0;
	logic [15:0]         period_count = '0;
	logic [4:0]          switch_bits = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [4:0]          load_on_bits;
	logic [4:0]          load_shed_bits;
	logic                grid_stable;
	logic                shedding_active;
	logic                maintenance_mode;
	logic [23:0]         frequency_mhz;
	logic signed [31:0]  roc_mhz_s;

	relay_word_t   word_queue[$];
	relay_status_t expected_status_q[$];
	int            errors = 0;
	int            cycles = 0;
	int            sender_idle_pct = 12;
	int            receiver_idle_pct = 56;
	logic          stall_req = 1'b0;
	int            hold_cnt = 0;

	logic [23:0] cfg_freq_thr = 24'd49000;
	logic [30:0] cfg_roc_thr = 31'd10000;
	logic [15:0] cfg_period = 16'd500;

	logic [23:0]        prev_freq = '0;
	mode_t              load_state[5] = '{default: MODE_OFF};
	logic               stable_m = 1'b1;
	logic               shedding_m = 1'b0;
	logic               maint_m = 1'b0;
	logic               timer_run = 1'b0;
	logic [15:0]        timer_cnt = '0;
	logic signed [31:0] roc_m = '0;

	frequency_relay_load_shedder_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready),
		.operation(operation), .period_count(period_count), .switch_bits(switch_bits),
		.result_valid(result_valid), .result_ready(result_ready),
		.load_on_bits(load_on_bits), .load_shed_bits(load_shed_bits),
		.grid_stable(grid_stable), .shedding_active(shedding_active),
		.maintenance_mode(maintenance_mode), .frequency_mhz(frequency_mhz),
		.roc_mhz_s(roc_mhz_s)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic signed [31:0] grid_rate(logic [23:0] f, logic [23:0] p);
		logic [127:0] fw, pw, dw, num, den, q;
		logic neg;
		fw = f;
		pw = p;
		if (fw + pw == 0)
			return 32'sd0;
		neg = f < p;
		dw = neg ? pw - fw : fw - pw;
		num = 128'd2 * dw * fw * pw;
		den = 128'd1000 * (fw + pw);
		q = num / den;
		if (neg)
			return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
		return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
	endfunction

	task automatic shed_lowest_on();
		for (int i = 0; i < 5; i++) begin
			if (load_state[i] == MODE_ON) begin
				load_state[i] = MODE_MANAGED;
				return;
			end
		end
	endtask

	task automatic relay_predict(input relay_word_t w);
		logic [23:0] f;
		logic [32:0] mag;
		logic unstable, any_on, any_managed, done;
		relay_status_t s;
		case (w.op)
			OP_SAMPLE: begin
				f = (w.count == 0) ? 24'd0 : 24'(32'd16000000 / w.count);
				roc_m = grid_rate(f, prev_freq);
				prev_freq = f;
				if (!maint_m) begin
					mag = roc_m[31] ? 33'(-$signed({roc_m[31], roc_m})) : 33'(roc_m);
					unstable = (f < cfg_freq_thr) || (mag >= {2'b00, cfg_roc_thr});
					if (unstable) begin
						if (stable_m) begin
							stable_m = 1'b0;
							timer_run = 1'b1;
							timer_cnt = '0;
						end
						any_on = 1'b0;
						foreach (load_state[i]) if (load_state[i] == MODE_ON) any_on = 1'b1;
						if (!shedding_m && any_on) begin
							shedding_m = 1'b1;
							shed_lowest_on();
						end
					end else if (!stable_m) begin
						stable_m = 1'b1;
						timer_run = 1'b1;
						timer_cnt = '0;
					end
				end
			end
			OP_TICK: begin
				if (timer_run) begin
					timer_cnt = timer_cnt + 16'd1;
					if (timer_cnt >= cfg_period) begin
						timer_cnt = '0;
						if (!maint_m) begin
							if (!stable_m) begin
								shed_lowest_on();
							end else begin
								done = 1'b0;
								for (int i = 4; i >= 0; i--) begin
									if (!done && load_state[i] == MODE_MANAGED) begin
										load_state[i] = MODE_ON;
										done = 1'b1;
									end
								end
								if (!done) begin
									shedding_m = 1'b0;
									timer_run = 1'b0;
								end
							end
						end
					end
				end
			end
			OP_SWITCH: begin
				for (int i = 0; i < 5; i++) begin
					if (shedding_m && !maint_m) begin
						if (!w.sw[i])
							load_state[i] = MODE_OFF;
					end else begin
						load_state[i] = w.sw[i] ? MODE_ON : MODE_OFF;
					end
				end
			end
			default: begin
				maint_m = ~maint_m;
				if (maint_m) begin
					shedding_m = 1'b0;
					timer_run = 1'b0;
					foreach (load_state[i])
						if (load_state[i] == MODE_MANAGED) load_state[i] = MODE_ON;
				end
			end
		endcase
		any_managed = 1'b0;
		foreach (load_state[i]) if (load_state[i] == MODE_MANAGED) any_managed = 1'b1;
		if (!any_managed) begin
			shedding_m = 1'b0;
			timer_run = 1'b0;
		end
		foreach (load_state[i]) begin
			s.on_bits[i] = (load_state[i] == MODE_ON);
			s.shed_bits[i] = (load_state[i] == MODE_MANAGED);
		end
		s.stable = stable_m;
		s.shedding = shedding_m;
		s.maint = maint_m;
		s.freq = prev_freq;
		s.roc = roc_m;
		expected_status_q.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				relay_predict('{op_t'(operation), period_count, switch_bits});
			if (!item_valid || item_ready) begin
				if (word_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					relay_word_t w;
					w = word_queue.pop_front();
					operation <= w.op;
					period_count <= w.count;
					switch_bits <= w.sw;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_status_q.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected, actual on %0h shed %0h",
						$time, load_on_bits, load_shed_bits);
				end else begin
					relay_status_t e;
					e = expected_status_q.pop_front();
					check_field("load_on_bits", e.on_bits, load_on_bits);
					check_field("load_shed_bits", e.shed_bits, load_shed_bits);
					check_field("grid_stable", e.stable, grid_stable);
					check_field("shedding_active", e.shedding, shedding_active);
					check_field("maintenance_mode", e.maint, maintenance_mode);
					check_field("frequency_mhz", e.freq, frequency_mhz);
					check_field("roc_mhz_s", e.roc, roc_mhz_s);
				end
			end
			if (stall_req) begin
				stall_req <= 1'b0;
				hold_cnt <= 400;
				result_ready <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	task automatic push_word(op_t op, logic [15:0] count, logic [4:0] sw);
		word_queue.push_back('{op, count, sw});
	endtask

	task automatic push_random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			if ($urandom_range(9) == 0)
				push_word(OP_SAMPLE, 16'($urandom_range(65535)), 5'($urandom));
			else
				push_word(OP_SAMPLE, 16'($urandom_range(345, 300)), 5'($urandom));
		end else if (pick < 77) begin
			push_word(OP_TICK, 16'($urandom), 5'($urandom));
		end else if (pick < 89) begin
			push_word(OP_SWITCH, 16'($urandom), 5'($urandom));
		end else if (pick < 92) begin
			push_word(OP_BUTTON, 16'($urandom), 5'($urandom));
		end else begin
			push_word(op_t'($urandom_range(3)), 16'($urandom), 5'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (word_queue.size() != 0 || item_valid || expected_status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FREQ_THR: cfg_freq_thr = value[23:0];
			REG_ROC_THR:  cfg_roc_thr = value[30:0];
			default:      cfg_period = value[15:0];
		endcase
	endtask

	task automatic run_phase(logic [31:0] fthr, logic [31:0] rthr, logic [31:0] per,
			int snd_idle, int rcv_idle, int n);
		reg_write(REG_FREQ_THR, fthr);
		reg_write(REG_ROC_THR, rthr);
		reg_write(REG_PERIOD, per);
		sender_idle_pct = snd_idle;
		receiver_idle_pct = rcv_idle;
		repeat (n) push_random_word();
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		push_word(OP_SWITCH, 16'h0000, 5'b11111);
		push_word(OP_SAMPLE, 16'd320, 5'b00000);
		push_word(OP_SAMPLE, 16'd321, 5'b11111);
		push_word(OP_SAMPLE, 16'd340, 5'b00000);
		push_word(OP_TICK, 16'hFFFF, 5'b00000);
		push_word(OP_SWITCH, 16'h0000, 5'b11100);
		push_word(OP_SWITCH, 16'hFFFF, 5'b00000);
		push_word(OP_SWITCH, 16'h0000, 5'b11111);
		push_word(OP_SAMPLE, 16'd0, 5'b00000);
		push_word(OP_SAMPLE, 16'd0, 5'b00000);
		push_word(OP_SAMPLE, 16'd1, 5'b00000);
		push_word(OP_SAMPLE, 16'd65535, 5'b00000);
		push_word(OP_SAMPLE, 16'd1, 5'b00000);
		push_word(OP_BUTTON, 16'h0000, 5'b00000);
		push_word(OP_SAMPLE, 16'd400, 5'b00000);
		push_word(OP_TICK, 16'h0000, 5'b00000);
		push_word(OP_SWITCH, 16'h0000, 5'b01010);
		push_word(OP_BUTTON, 16'hFFFF, 5'b11111);
		push_word(OP_SAMPLE, 16'd320, 5'b00000);
		push_word(OP_SAMPLE, 16'd320, 5'b00000);
		wait_drained();

		reg_write(REG_PERIOD, 32'd0);
		push_word(OP_SWITCH, 16'h0000, 5'b10101);
		push_word(OP_SAMPLE, 16'd360, 5'b00000);
		push_word(OP_TICK, 16'h0000, 5'b00000);
		push_word(OP_TICK, 16'h0000, 5'b00000);
		push_word(OP_SAMPLE, 16'd320, 5'b00000);
		push_word(OP_TICK, 16'h0000, 5'b00000);
		push_word(OP_TICK, 16'h0000, 5'b00000);
		push_word(OP_TICK, 16'h0000, 5'b00000);
		wait_drained();

		run_phase(32'd49000, 32'd10000, 32'd0, 12, 56, 290);
		run_phase(32'd0, 32'd0, 32'd1, 12, 56, 290);
		stall_req = 1'b1;
		run_phase(32'd16000000, 32'h7FFF_FFFF, 32'd3, 56, 12, 290);
		run_phase(32'd49500, 32'd5000, 32'd2, 56, 12, 290);
		run_phase(32'd48000, 32'd20000, 32'd65535, 0, 0, 140);
		run_phase(32'd49000, 32'd10000, 32'd5, 0, 0, 150);
		repeat (270) push_random_word();
		wait_drained();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
